@@ rtl/core/qte_pkg.sv @@
// qte_pkg: widths, codes, command/status types and constant tables
// for the relative quaternion to euler block; depends on nothing
package qte_pkg;

  localparam int QUAT_W       = 16;
  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int RF           = 14;

  // quaternion product rounding shift and derived widths
  localparam int QRND_K  = 2 * (QUAT_W - 2) - RF - 2;
  localparam int R_W     = 2 * QUAT_W - QRND_K;
  localparam int QACC_W  = 2 * QUAT_W + 4;
  localparam int ACC_W   = 2 * R_W + 4;
  localparam int MUL_W   = (QUAT_W > 2 * RF + 2) ? QUAT_W : 2 * RF + 2;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CX_W    = ACC_W + 4;
  localparam int Z_W     = 32;
  localparam int SQ_W    = 4 * RF + 2;
  localparam int SQRT_W  = 2 * RF + 1;
  localparam int CI_W    = $clog2(CORDIC_STEPS);
  localparam int STEP_W  = 4;

  localparam int ANGLE_SH  = (ANGLE_W < Z_W) ? (Z_W - 1 - ANGLE_W) : 0;
  localparam int ANGLE_RND = (ANGLE_W < Z_W) ? 1 : 0;

  localparam logic [Z_W-1:0] PITCH_UP = 32'h4000_0000;
  localparam logic [Z_W-1:0] PITCH_DN = 32'hC000_0000;
  localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

  // cordic job select
  localparam logic [1:0] CSEL_YAW   = 2'd0;
  localparam logic [1:0] CSEL_ROLL  = 2'd1;
  localparam logic [1:0] CSEL_PITCH = 2'd2;

  // euler accumulator slots
  localparam int EA_YY = 0;  // yaw numerator
  localparam int EA_YX = 1;  // yaw denominator
  localparam int EA_LY = 2;  // roll numerator
  localparam int EA_LX = 3;  // roll denominator
  localparam int EA_SP = 4;  // pitch sine term
  localparam int EA_N  = 5;

  typedef struct packed {
    logic              load_in;
    logic              qmul_go;
    logic              emul_go;
    logic [STEP_W-1:0] step_idx;
    logic              recap_apply;
    logic              emul_init;
    logic              sq_mul_go;
    logic              sqrt_step;
    logic              cord_init;
    logic              cord_step;
    logic              cord_store;
    logic [1:0]        cord_sel;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic clamped;
    logic sqrt_done;
    logic cord_last;
  } sts_t;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic       neg;
  } qsel_t;

  typedef struct packed {
    logic [1:0]      a;
    logic [1:0]      b;
    logic [EA_N-1:0] mask;
    logic            neg;
  } esel_t;

  // conj(origin) * q: origin index, sample index, sign of each product
  function automatic qsel_t qsel(input logic [STEP_W-1:0] idx);
    qsel_t s;
    case (idx)
      4'd0:    s = '{2'd0, 2'd0, 1'b0};
      4'd1:    s = '{2'd1, 2'd1, 1'b0};
      4'd2:    s = '{2'd2, 2'd2, 1'b0};
      4'd3:    s = '{2'd3, 2'd3, 1'b0};
      4'd4:    s = '{2'd0, 2'd1, 1'b0};
      4'd5:    s = '{2'd1, 2'd0, 1'b1};
      4'd6:    s = '{2'd2, 2'd3, 1'b1};
      4'd7:    s = '{2'd3, 2'd2, 1'b0};
      4'd8:    s = '{2'd0, 2'd2, 1'b0};
      4'd9:    s = '{2'd1, 2'd3, 1'b0};
      4'd10:   s = '{2'd2, 2'd0, 1'b1};
      4'd11:   s = '{2'd3, 2'd1, 1'b1};
      4'd12:   s = '{2'd0, 2'd3, 1'b0};
      4'd13:   s = '{2'd1, 2'd2, 1'b1};
      4'd14:   s = '{2'd2, 2'd1, 1'b0};
      4'd15:   s = '{2'd3, 2'd0, 1'b1};
      default: s = '{2'd0, 2'd0, 1'b0};
    endcase
    return s;
  endfunction

  // euler products: r operands (w x y z), target accumulators, sign
  function automatic esel_t esel(input logic [STEP_W-1:0] idx);
    esel_t s;
    case (idx)
      4'd0:    s = '{2'd0, 2'd3, 5'b00001, 1'b0};
      4'd1:    s = '{2'd1, 2'd2, 5'b00001, 1'b0};
      4'd2:    s = '{2'd2, 2'd2, 5'b01010, 1'b1};
      4'd3:    s = '{2'd3, 2'd3, 5'b00010, 1'b1};
      4'd4:    s = '{2'd0, 2'd1, 5'b00100, 1'b0};
      4'd5:    s = '{2'd2, 2'd3, 5'b00100, 1'b0};
      4'd6:    s = '{2'd1, 2'd1, 5'b01000, 1'b1};
      4'd7:    s = '{2'd0, 2'd2, 5'b10000, 1'b0};
      4'd8:    s = '{2'd3, 2'd1, 5'b10000, 1'b1};
      default: s = '{2'd0, 2'd0, 5'b00000, 1'b0};
    endcase
    return s;
  endfunction

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [Z_W-1:0] atan_tab(input logic [4:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // round half up to ANGLE_W bits, wrapping
  function automatic logic [ANGLE_W-1:0] angle_out(input logic [Z_W-1:0] z);
    logic [Z_W:0] v;
    v = {1'b0, z} + ((Z_W + 1)'(ANGLE_RND) << ANGLE_SH);
    return v[Z_W-1 -: ANGLE_W];
  endfunction

endpackage

@@ rtl/core/qte_if.sv @@
// qte_if: valid/ready channel interfaces for samples and angle results
// depends on qte_pkg for field widths
interface qte_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [qte_pkg::QUAT_W-1:0]  quat_w;
  logic signed [qte_pkg::QUAT_W-1:0]  quat_x;
  logic signed [qte_pkg::QUAT_W-1:0]  quat_y;
  logic signed [qte_pkg::QUAT_W-1:0]  quat_z;
  logic                               recapture;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, recapture, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, recapture, output ready);
endinterface

interface qte_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qte_pkg::ANGLE_W-1:0] roll_angle;
  logic signed [qte_pkg::ANGLE_W-1:0] pitch_angle;
  logic signed [qte_pkg::ANGLE_W-1:0] yaw_angle;
  logic                               pitch_clamped;
  logic                               origin_captured;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  origin_captured, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  origin_captured, output ready);
endinterface

@@ rtl/core/qte_datapath.sv @@
// qte_datapath: origin store, shared multiplier, accumulators, square root
// and cordic unit, result register; depends on qte_pkg
module qte_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  qte_pkg::cmd_t                      cmd,
  output qte_pkg::sts_t                      sts,
  input  logic signed [qte_pkg::QUAT_W-1:0]  in_quat_w,
  input  logic signed [qte_pkg::QUAT_W-1:0]  in_quat_x,
  input  logic signed [qte_pkg::QUAT_W-1:0]  in_quat_y,
  input  logic signed [qte_pkg::QUAT_W-1:0]  in_quat_z,
  input  logic                               in_recapture,
  output logic signed [qte_pkg::ANGLE_W-1:0] out_roll_angle,
  output logic signed [qte_pkg::ANGLE_W-1:0] out_pitch_angle,
  output logic signed [qte_pkg::ANGLE_W-1:0] out_yaw_angle,
  output logic                               out_pitch_clamped,
  output logic                               out_origin_captured
);

  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_Q    = 2'd1;
  localparam logic [1:0] PK_E    = 2'd2;
  localparam logic [1:0] PK_S    = 2'd3;

  localparam logic signed [qte_pkg::QACC_W-1:0] QRND_HALF =
    qte_pkg::QACC_W'(1) <<< (qte_pkg::QRND_K - 1);
  localparam logic signed [qte_pkg::ACC_W-1:0] ONE_ACC =
    qte_pkg::ACC_W'(1) <<< (2 * qte_pkg::RF);
  localparam logic [qte_pkg::SQ_W-1:0] SQ_ONE = qte_pkg::SQ_W'(1) << (4 * qte_pkg::RF);

  logic signed [qte_pkg::QUAT_W-1:0] q_r   [4];
  logic signed [qte_pkg::QUAT_W-1:0] org_r [4];
  logic                              org_valid_r;
  logic                              recap_r;
  logic                              captured_r;

  logic signed [qte_pkg::MUL_W-1:0]  ma, mb;
  logic signed [qte_pkg::PROD_W-1:0] prod_r;
  logic [1:0]                        pkind_r;
  logic [qte_pkg::STEP_W-1:0]        pidx_r;

  logic signed [qte_pkg::QACC_W-1:0] qacc_r;
  logic signed [qte_pkg::R_W-1:0]    r_r [4];
  logic signed [qte_pkg::ACC_W-1:0]  eacc_r [qte_pkg::EA_N];

  logic [qte_pkg::SQ_W-1:0] v_r, res_r, bit_r;

  logic signed [qte_pkg::CX_W-1:0] cx_r, cy_r;
  logic [qte_pkg::Z_W-1:0]         cz_r;
  logic [qte_pkg::CI_W-1:0]        ci_r;
  logic                            czero_r;
  logic [qte_pkg::Z_W-1:0]         yaw_z_r, roll_z_r, pitch_z_r;

  qte_pkg::qsel_t qs_i, qs_d;
  qte_pkg::esel_t es_i, es_d;

  logic signed [qte_pkg::PROD_W-1:0] pq, p4;
  logic signed [qte_pkg::QACC_W-1:0] qsum;
  logic signed [qte_pkg::ACC_W-1:0]  eterm;
  logic signed [qte_pkg::ACC_W-1:0]  sp;
  logic                              clamped;
  logic [qte_pkg::SQ_W-1:0]          trial;
  logic signed [qte_pkg::CX_W-1:0]   iy, ix;

  assign sp      = eacc_r[qte_pkg::EA_SP];
  assign clamped = (sp >= ONE_ACC) || (sp <= -ONE_ACC);

  assign sts.clamped   = clamped;
  assign sts.sqrt_done = (bit_r == '0);
  assign sts.cord_last = (ci_r == qte_pkg::CI_W'(qte_pkg::CORDIC_STEPS - 1));

  // sample and origin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_valid_r <= 1'b0;
      org_r[0]    <= qte_pkg::QUAT_W'(1) << (qte_pkg::QUAT_W - 2);
      org_r[1]    <= '0;
      org_r[2]    <= '0;
      org_r[3]    <= '0;
    end else if (cmd.load_in && !org_valid_r) begin
      org_valid_r <= 1'b1;
      org_r[0]    <= in_quat_w;
      org_r[1]    <= in_quat_x;
      org_r[2]    <= in_quat_y;
      org_r[3]    <= in_quat_z;
    end else if (cmd.recap_apply && recap_r) begin
      org_valid_r <= 1'b1;
      org_r       <= q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      q_r[0]     <= in_quat_w;
      q_r[1]     <= in_quat_x;
      q_r[2]     <= in_quat_y;
      q_r[3]     <= in_quat_z;
      recap_r    <= in_recapture;
      captured_r <= !org_valid_r;
    end
  end

  // shared multiplier operand select
  always_comb begin
    qs_i = qte_pkg::qsel(cmd.step_idx);
    es_i = qte_pkg::esel(cmd.step_idx);
    ma   = '0;
    mb   = '0;
    if (cmd.qmul_go) begin
      ma = qte_pkg::MUL_W'(org_r[qs_i.a]);
      mb = qte_pkg::MUL_W'(q_r[qs_i.b]);
    end else if (cmd.emul_go) begin
      ma = qte_pkg::MUL_W'(r_r[es_i.a]);
      mb = qte_pkg::MUL_W'(r_r[es_i.b]);
    end else if (cmd.sq_mul_go) begin
      ma = sp[qte_pkg::MUL_W-1:0];
      mb = sp[qte_pkg::MUL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkind_r <= PK_NONE;
    end else if (cmd.qmul_go) begin
      pkind_r <= PK_Q;
    end else if (cmd.emul_go) begin
      pkind_r <= PK_E;
    end else if (cmd.sq_mul_go) begin
      pkind_r <= PK_S;
    end else begin
      pkind_r <= PK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    pidx_r <= cmd.step_idx;
  end

  // accumulate stage
  always_comb begin
    qs_d  = qte_pkg::qsel(pidx_r);
    es_d  = qte_pkg::esel(pidx_r);
    pq    = qs_d.neg ? -prod_r : prod_r;
    p4    = pq >>> 2;
    qsum  = ((pidx_r[1:0] == 2'd0) ? '0 : qacc_r) + qte_pkg::QACC_W'(p4);
    eterm = qte_pkg::ACC_W'(prod_r) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (pkind_r == PK_Q) begin
      qacc_r <= qsum;
      if (pidx_r[1:0] == 2'd3) begin
        r_r[pidx_r[3:2]] <= qte_pkg::R_W'((qsum + QRND_HALF) >>> qte_pkg::QRND_K);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emul_init) begin
      eacc_r[qte_pkg::EA_YY] <= '0;
      eacc_r[qte_pkg::EA_YX] <= ONE_ACC;
      eacc_r[qte_pkg::EA_LY] <= '0;
      eacc_r[qte_pkg::EA_LX] <= ONE_ACC;
      eacc_r[qte_pkg::EA_SP] <= '0;
    end else if (pkind_r == PK_E) begin
      for (int k = 0; k < qte_pkg::EA_N; k++) begin
        if (es_d.mask[k]) begin
          eacc_r[k] <= es_d.neg ? (eacc_r[k] - eterm) : (eacc_r[k] + eterm);
        end
      end
    end
  end

  // bitwise floor square root of one minus sine squared
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (pkind_r == PK_S) begin
      bit_r <= SQ_ONE;
    end else if (cmd.sqrt_step) begin
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (pkind_r == PK_S) begin
      v_r   <= SQ_ONE - prod_r[qte_pkg::SQ_W-1:0];
      res_r <= '0;
    end else if (cmd.sqrt_step) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
    end
  end

  // cordic vectoring
  always_comb begin
    case (cmd.cord_sel)
      qte_pkg::CSEL_YAW: begin
        iy = qte_pkg::CX_W'(eacc_r[qte_pkg::EA_YY]);
        ix = qte_pkg::CX_W'(eacc_r[qte_pkg::EA_YX]);
      end
      qte_pkg::CSEL_ROLL: begin
        iy = qte_pkg::CX_W'(eacc_r[qte_pkg::EA_LY]);
        ix = qte_pkg::CX_W'(eacc_r[qte_pkg::EA_LX]);
      end
      default: begin
        iy = qte_pkg::CX_W'(sp);
        ix = qte_pkg::CX_W'({1'b0, res_r[qte_pkg::SQRT_W-1:0]});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      czero_r <= (ix == '0) && (iy == '0);
      ci_r    <= '0;
      if (ix < 0) begin
        cx_r <= -ix;
        cy_r <= -iy;
        cz_r <= qte_pkg::HALF_TURN;
      end else begin
        cx_r <= ix;
        cy_r <= iy;
        cz_r <= '0;
      end
    end else if (cmd.cord_step) begin
      ci_r <= ci_r + 1'b1;
      if (cy_r >= 0) begin
        cx_r <= cx_r + (cy_r >>> ci_r);
        cy_r <= cy_r - (cx_r >>> ci_r);
        cz_r <= cz_r + qte_pkg::atan_tab(5'(ci_r));
      end else begin
        cx_r <= cx_r - (cy_r >>> ci_r);
        cy_r <= cy_r + (cx_r >>> ci_r);
        cz_r <= cz_r - qte_pkg::atan_tab(5'(ci_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cord_store) begin
      case (cmd.cord_sel)
        qte_pkg::CSEL_YAW:  yaw_z_r   <= czero_r ? '0 : cz_r;
        qte_pkg::CSEL_ROLL: roll_z_r  <= czero_r ? '0 : cz_r;
        default:            pitch_z_r <= czero_r ? '0 : cz_r;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_roll_angle      <= qte_pkg::angle_out(roll_z_r);
      out_yaw_angle       <= qte_pkg::angle_out(yaw_z_r);
      out_pitch_angle     <= qte_pkg::angle_out(!clamped ? pitch_z_r :
                                                (sp > 0) ? qte_pkg::PITCH_UP :
                                                           qte_pkg::PITCH_DN);
      out_pitch_clamped   <= clamped;
      out_origin_captured <= captured_r;
    end
  end

  a_sqrt_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_step |-> (bit_r != '0))
    else $error("square root stepped past its last bit");

  a_pitch_unclamped: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cord_init && cmd.cord_sel == qte_pkg::CSEL_PITCH) |-> !clamped)
    else $error("pitch cordic started on a clamped sine");

  a_origin_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> org_valid_r)
    else $error("origin not held after a sample");

endmodule

@@ rtl/core/qte_ctrl.sv @@
// qte_ctrl: sequencer for one sample through multiply, square root and
// cordic phases, plus result-register handshake; depends on qte_pkg
module qte_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output qte_pkg::cmd_t cmd,
  input  qte_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_QMUL  = 4'd1;
  localparam logic [3:0] S_QDRN  = 4'd2;
  localparam logic [3:0] S_EMUL  = 4'd3;
  localparam logic [3:0] S_EDRN  = 4'd4;
  localparam logic [3:0] S_CINIT = 4'd5;
  localparam logic [3:0] S_CRUN  = 4'd6;
  localparam logic [3:0] S_CSTO  = 4'd7;
  localparam logic [3:0] S_PCHK  = 4'd8;
  localparam logic [3:0] S_SQW   = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  localparam logic [qte_pkg::STEP_W-1:0] Q_LAST = 4'd15;
  localparam logic [qte_pkg::STEP_W-1:0] E_LAST = 4'd8;

  logic [3:0]                 st_r, st_nxt;
  logic [qte_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                 csel_r, csel_nxt;
  logic                       out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;
  assign in_ready  = (st_r == S_IDLE);

  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    csel_nxt     = csel_r;
    cmd          = '0;
    cmd.step_idx = cnt_r;
    cmd.cord_sel = csel_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          st_nxt      = S_QMUL;
        end
      end
      S_QMUL: begin
        cmd.qmul_go = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == Q_LAST) begin
          cnt_nxt = '0;
          st_nxt  = S_QDRN;
        end
      end
      S_QDRN: begin
        cmd.recap_apply = 1'b1;
        cmd.emul_init   = 1'b1;
        st_nxt          = S_EMUL;
      end
      S_EMUL: begin
        cmd.emul_go = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == E_LAST) begin
          cnt_nxt = '0;
          st_nxt  = S_EDRN;
        end
      end
      S_EDRN: begin
        csel_nxt = qte_pkg::CSEL_YAW;
        st_nxt   = S_CINIT;
      end
      S_CINIT: begin
        cmd.cord_init = 1'b1;
        st_nxt        = S_CRUN;
      end
      S_CRUN: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_last) begin
          st_nxt = S_CSTO;
        end
      end
      S_CSTO: begin
        cmd.cord_store = 1'b1;
        case (csel_r)
          qte_pkg::CSEL_YAW: begin
            csel_nxt = qte_pkg::CSEL_ROLL;
            st_nxt   = S_CINIT;
          end
          qte_pkg::CSEL_ROLL: st_nxt = S_PCHK;
          default:            st_nxt = S_FIN;
        endcase
      end
      S_PCHK: begin
        if (sts.clamped) begin
          st_nxt = S_FIN;
        end else begin
          cmd.sq_mul_go = 1'b1;
          st_nxt        = S_SQW;
        end
      end
      S_SQW: begin
        st_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          csel_nxt = qte_pkg::CSEL_PITCH;
          st_nxt   = S_CINIT;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      csel_r      <= qte_pkg::CSEL_YAW;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      csel_r      <= csel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second sample taken while one is in flight");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded but not presented");

  a_sqrt_after_roll: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SQRT) |-> (csel_r == qte_pkg::CSEL_ROLL))
    else $error("square root phase out of order");

endmodule

@@ rtl/core/relative_quaternion_to_euler.sv @@
// relative_quaternion_to_euler: top level, joins the sequencer and datapath
// to the sample and result channels; depends on qte_pkg, qte_if, qte_ctrl, qte_datapath
//
// Takes one attitude quaternion (Q1.14) per beat and returns roll, pitch and
// yaw of the rotation relative to a held origin, as binary angles where
// 32768 is pi (+pi wraps to -32768). The first beat after reset becomes the
// origin (origin_captured set); a beat with recapture set replaces the origin
// after its own relative rotation is formed. When |2(wy-zx)| reaches one, pitch reads
// +/-pi/2 and pitch_clamped is set. One sample is worked at a time: the next
// is taken once the last result is in the output register; a pitch clamp
// skips the square root and pitch cordic. The time is set by one shared
// signed multiplier (16 products for the relative quaternion, 9 for the
// euler terms, one for the pitch cosine), a one-bit-per-cycle square root
// (29 steps) and one shared cordic unit run three times at 16 steps each
// (twice when pitch clamps). The result sits in an output register, so a
// new sample is taken while the previous result still waits on the sink.
module relative_quaternion_to_euler (
  input  logic      clk,
  input  logic      rst_n,
  qte_in_if.sink    in_bus,
  qte_out_if.source out_bus
);

  qte_pkg::cmd_t cmd;
  qte_pkg::sts_t sts;

  logic                               ctl_in_ready;
  logic                               ctl_out_valid;
  logic signed [qte_pkg::ANGLE_W-1:0] roll_angle;
  logic signed [qte_pkg::ANGLE_W-1:0] pitch_angle;
  logic signed [qte_pkg::ANGLE_W-1:0] yaw_angle;
  logic                               pitch_clamped;
  logic                               origin_captured;

  // phase sequencing and channel handshakes
  qte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (ctl_in_ready),
    .out_valid (ctl_out_valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic, origin store and result register
  qte_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_quat_w           (in_bus.quat_w),
    .in_quat_x           (in_bus.quat_x),
    .in_quat_y           (in_bus.quat_y),
    .in_quat_z           (in_bus.quat_z),
    .in_recapture        (in_bus.recapture),
    .out_roll_angle      (roll_angle),
    .out_pitch_angle     (pitch_angle),
    .out_yaw_angle       (yaw_angle),
    .out_pitch_clamped   (pitch_clamped),
    .out_origin_captured (origin_captured)
  );

  assign in_bus.ready            = ctl_in_ready;
  assign out_bus.valid           = ctl_out_valid;
  assign out_bus.roll_angle      = roll_angle;
  assign out_bus.pitch_angle     = pitch_angle;
  assign out_bus.yaw_angle       = yaw_angle;
  assign out_bus.pitch_clamped   = pitch_clamped;
  assign out_bus.origin_captured = origin_captured;

endmodule

@@ bench/relative_quaternion_to_euler_test.sv @@
// relative_quaternion_to_euler_test: self-checking bench for the relative
// quaternion to euler block; depends on qte_pkg, qte_if and the block itself
`timescale 1ns / 100ps

module relative_quaternion_to_euler_test;

  localparam int N_RANDOM   = 1280;
  localparam int IDLE_LIMIT = 5000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES = 700;  // long receiver hold-off
  localparam int DRAIN_LIMIT = 20000;

  typedef logic signed [qte_pkg::QUAT_W-1:0]  quat_t;
  typedef logic signed [qte_pkg::ANGLE_W-1:0] ang_t;

  // one expected result beat
  typedef struct {
    ang_t roll;
    ang_t pitch;
    ang_t yaw;
    logic clamped;
    logic captured;
  } euler_t;

  // predicts the euler result of each accepted sample and checks results in order
  class euler_scoreboard;
    euler_t       pending_q[$];
    longint       origin[4];
    bit           have_origin;
    int           mismatches;
    int           n_checked;
    int           n_clamped;
    int           n_captured;
    bit [31:0]    atan_lut[32];

    function void init();
      atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                   83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                   81, 41, 20, 10, 5, 3, 1, 1, 0};
      origin = '{longint'(1) << (qte_pkg::QUAT_W - 2), 0, 0, 0};
      have_origin = 0;
      mismatches = 0;
      n_checked = 0;
      n_clamped = 0;
      n_captured = 0;
    endfunction

    // four exact products, each floored by 4, summed and rounded to q.14
    function longint prod_sum(longint a0, longint b0, longint a1, longint b1,
                              longint a2, longint b2, longint a3, longint b3);
      longint s;
      s = ((a0 * b0) >>> 2) + ((a1 * b1) >>> 2) + ((a2 * b2) >>> 2) + ((a3 * b3) >>> 2);
      return (s + (longint'(1) << (qte_pkg::QRND_K - 1))) >>> qte_pkg::QRND_K;
    endfunction

    function longint floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return longint'(res);
    endfunction

    // vectoring rotation to a 32-bit binary angle
    function bit [31:0] vector_angle(longint y, longint x);
      bit [31:0] z;
      longint dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_lut[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_lut[i];
        end
      end
      return z;
    endfunction

    function ang_t to_angle(bit [31:0] z);
      longint unsigned v;
      v = z;
      v = (v + (64'd1 << (31 - qte_pkg::ANGLE_W))) >> (32 - qte_pkg::ANGLE_W);
      return ang_t'(v);
    endfunction

    function void note_sample(quat_t w, quat_t x, quat_t y, quat_t z, logic recap);
      longint q[4];
      longint ow, ox, oy, oz, rw, rx, ry, rz, sp, one;
      longint unsigned s2;
      euler_t e;
      q = '{w, x, y, z};
      one = longint'(1) << (2 * qte_pkg::RF);
      e.captured = 0;
      e.clamped = 0;
      if (!have_origin) begin
        origin = q;
        have_origin = 1;
        e.captured = 1;
      end
      ow = origin[0];
      ox = -origin[1];
      oy = -origin[2];
      oz = -origin[3];
      rw = prod_sum(ow, q[0], -ox, q[1], -oy, q[2], -oz, q[3]);
      rx = prod_sum(ow, q[1], ox, q[0], oy, q[3], -oz, q[2]);
      ry = prod_sum(ow, q[2], -ox, q[3], oy, q[0], oz, q[1]);
      rz = prod_sum(ow, q[3], ox, q[2], -oy, q[1], oz, q[0]);
      e.yaw = to_angle(vector_angle(2 * (rw * rz + rx * ry), one - 2 * (ry * ry + rz * rz)));
      e.roll = to_angle(vector_angle(2 * (rw * rx + ry * rz), one - 2 * (rx * rx + ry * ry)));
      sp = 2 * (rw * ry - rz * rx);
      if (sp >= one || sp <= -one) begin
        e.clamped = 1;
        e.pitch = to_angle(sp > 0 ? 32'h4000_0000 : 32'hC000_0000);
      end else begin
        s2 = longint'(sp * sp);
        e.pitch = to_angle(vector_angle(sp,
                           floor_sqrt((64'd1 << (4 * qte_pkg::RF)) - s2)));
      end
      if (recap) origin = q;
      n_clamped += e.clamped;
      n_captured += e.captured;
      pending_q.push_back(e);
    endfunction

    function void check_result(ang_t roll, ang_t pitch, ang_t yaw, logic clamped,
                               logic captured);
      euler_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result beat: roll %0d pitch %0d yaw %0d",
                   $realtime, roll, pitch, yaw);
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (roll !== e.roll || pitch !== e.pitch || yaw !== e.yaw ||
          clamped !== e.clamped || captured !== e.captured) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result %0d: exp r/p/y %0d/%0d/%0d clamp %0b cap %0b",
                   $realtime, n_checked, e.roll, e.pitch, e.yaw, e.clamped, e.captured);
          $display("    got r/p/y %0d/%0d/%0d clamp %0b cap %0b",
                   roll, pitch, yaw, clamped, captured);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  qte_in_if  in_bus ();
  qte_out_if out_bus ();

  relative_quaternion_to_euler dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  euler_scoreboard sb;
  int  idle_cycles;
  int  n_recaptures;
  bit  hold_req;    // sender asks the receiver for a long hold-off
  bit  draining;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // beat monitors: sampled at the edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      sb.note_sample(in_bus.quat_w, in_bus.quat_x, in_bus.quat_y, in_bus.quat_z,
                     in_bus.recapture);
      n_recaptures += in_bus.recapture;
    end
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.roll_angle, out_bus.pitch_angle, out_bus.yaw_angle,
                      out_bus.pitch_clamped, out_bus.origin_captured);
  end

  // watchdog on cycles with no beat at all
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (!in_bus.valid && sb.pending_q.size() == 0 && !draining))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: stall pattern is re-picked at random from four, plus one long hold-off
  initial begin
    int mode;
    int cyc;
    bit did_hold;
    out_bus.ready = 1'b0;
    did_hold = 0;
    cyc = 0;
    mode = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !did_hold) begin
        did_hold = 1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (cyc % 200 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= (cyc % 4) != 3;
        2:       out_bus.ready <= ($urandom_range(0, 1) == 1);
        default: out_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
      cyc++;
      @(posedge clk);
    end
  end

  int burst_left;

  // offer one sample and hold it until accepted; gaps come between bursts
  task automatic send_sample(int w, int x, int y, int z, bit recap);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid <= 1'b1;
    in_bus.quat_w <= quat_t'(w);
    in_bus.quat_x <= quat_t'(x);
    in_bus.quat_y <= quat_t'(y);
    in_bus.quat_z <= quat_t'(z);
    in_bus.recapture <= recap;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // random attitude near the unit sphere, rounded to q1.14
  task automatic send_unit(bit recap);
    real c[4];
    real n;
    int q[4];
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'($urandom_range(0, 65536)) - 32768.0;
      n += c[i] * c[i];
    end
    if (n < 1.0) begin
      c[0] = 1.0;
      n = 1.0;
    end
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) begin
      c[i] = c[i] / n * 16384.0;
      q[i] = $rtoi(c[i] >= 0.0 ? c[i] + 0.5 : c[i] - 0.5);
      if (q[i] > 16384) q[i] = 16384;
      if (q[i] < -16384) q[i] = -16384;
    end
    send_sample(q[0], q[1], q[2], q[3], recap);
  endtask

  function automatic int any_comp();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  initial begin
    int kind;
    int waited;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.quat_w = '0;
    in_bus.quat_x = '0;
    in_bus.quat_y = '0;
    in_bus.quat_z = '0;
    in_bus.recapture = 1'b0;
    sb = new();
    sb.init();
    hold_req = 0;
    draining = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first beat is identity with recapture, so later samples read absolute
    send_sample(16384, 0, 0, 0, 1'b1);
    send_sample(0, 0, 8192, 8192, 1'b0);          // yaw vector is exactly zero
    send_sample(0, 8192, 8192, 0, 1'b0);          // roll vector is exactly zero
    send_sample(16384, 0, 16384, 0, 1'b0);        // pitch clamps upward
    send_sample(16384, 0, -16384, 0, 1'b0);       // pitch clamps downward
    send_sample(0, 0, 16384, 0, 1'b0);            // negative abscissa, half turn
    send_sample(0, 16384, 0, 0, 1'b0);
    send_sample(0, 0, 0, 16384, 1'b0);
    send_sample(0, 0, 0, 0, 1'b0);                // null sample
    send_sample(-16384, -16384, -16384, -16384, 1'b0);
    send_sample(16384, 16384, 16384, 16384, 1'b0);
    send_sample(11585, 11585, 0, 0, 1'b0);
    send_sample(11585, 0, 11585, 0, 1'b0);        // right at the clamp boundary
    send_sample(11585, 0, 0, -11585, 1'b0);
    send_sample(-16384, 0, 0, 0, 1'b1);           // recapture with the negated identity
    send_sample(16384, 0, 0, 0, 1'b0);
    send_sample(-1, 1, -1, 1, 1'b0);
    send_sample(16384, -16384, 16384, -16384, 1'b1);
    send_sample(16384, 0, 0, 0, 1'b0);
    send_sample(16384, 0, 0, 0, 1'b1);

    for (int n = 0; n < N_RANDOM; n++) begin
      // long receiver hold-off while the sender keeps offering
      if (n == 300) hold_req = 1;
      // let the block empty out once before continuing
      if (n == 800) begin
        in_bus.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 99);
      if (kind < 80)
        send_unit($urandom_range(0, 15) == 0);
      else if (kind < 92)
        send_sample(any_comp(), any_comp(), any_comp(), any_comp(),
                    ($urandom_range(0, 1) == 1));
      else if (kind < 96)
        // arbitrary components with no recapture, relative to the held origin
        send_sample(any_comp(), any_comp(), any_comp(), any_comp(), 1'b0);
      else
        send_sample(($urandom_range(0, 1) ? 16384 : -16384), 0,
                    ($urandom_range(0, 1) ? 16384 : -16384), 0,
                    ($urandom_range(0, 1) == 1));
    end
    in_bus.valid <= 1'b0;

    draining = 1;
    waited = 0;
    while (sb.pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);

    $display("checked %0d results: %0d pitch clamps, %0d origin captures, %0d recaptures",
             sb.n_checked, sb.n_clamped, sb.n_captured, n_recaptures);
    $display("mismatches %0d, results still outstanding %0d", sb.mismatches,
             sb.pending_q.size());
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
